// ===== hw/rtl/bsc_pkg.sv =====
// Shared constants, codes, state and command/status types for the safety checker.
package bsc_pkg;

    localparam int MAX_PROCS    = 16;
    localparam int MAX_RES      = 16;
    localparam int COUNT_BITS   = 16;
    localparam int VALUE_BITS   = 16;
    localparam int OP_BITS      = 2;
    localparam int NUM_BITS     = 5;
    localparam int CFG_IDX_BITS = 1;
    localparam int PROC_BITS    = $clog2(MAX_PROCS);
    localparam int RES_BITS     = $clog2(MAX_RES);
    // work grows by at most MAX_PROCS allocations on top of the available count
    localparam int WORK_BITS    = COUNT_BITS + PROC_BITS + 1;
    localparam int NEED_BITS    = WORK_BITS + 1;

    typedef enum logic [OP_BITS-1:0] {
        OP_WRITE_ALLOC = 2'd0,
        OP_WRITE_CLAIM = 2'd1,
        OP_WRITE_AVAIL = 2'd2,
        OP_CHECK       = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_NUM_PROCESSES = 1'b0,
        CFG_NUM_RESOURCES = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic start;
        logic scan;
        logic wrap;
        logic advance;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_is_check;
        logic grant_now;
        logic pass_granted;
        logic last_proc;
        logic last_pass;
        logic all_now;
        logic out_free;
        logic emit_last;
    } t_dp_status;

    function automatic logic [NUM_BITS-1:0] clamp_count(
        input logic [NUM_BITS-1:0] v,
        input logic [NUM_BITS-1:0] hi
    );
        if (v == '0) begin
            return NUM_BITS'(1);
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/bsc_if.sv =====
// Valid/ready channel interfaces: load/check items, results and register writes.
interface bsc_item_if import bsc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [OP_BITS-1:0]    opcode;
    logic [PROC_BITS-1:0]  process_index;
    logic [RES_BITS-1:0]   resource_index;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, opcode, process_index, resource_index, value, input ready);
    modport sink   (input valid, opcode, process_index, resource_index, value, output ready);
endinterface

interface bsc_result_if import bsc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 safe;
    logic [PROC_BITS-1:0] process_id;
    logic                 last;

    modport source (output valid, safe, process_id, last, input ready);
    modport sink   (input valid, safe, process_id, last, output ready);
endinterface

interface bsc_cfg_if import bsc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [NUM_BITS-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/bankers_safety_check_top.sv =====
// Top level of the deadlock-avoidance safety checker.
//
//   channel   | dir | payload                                          | transfer
//   i_item    | in  | opcode, process_index, resource_index, value     | valid & ready
//   o_result  | out | safe, process_id, last                           | valid & ready
//   i_cfg     | in  | index (0 processes, 1 resources), data           | valid & ready
//
// A load is taken while idle. A check is accepted, then scans the processes pass by pass,
// visiting at most num_processes * num_processes (256) processes, then emits its results.
// Each visit reads one row of both tables from the per-column RAMs and compares all
// resources at once. Reset is synchronous and active low; tables need no clearing.
// Loads are taken while the last result still waits in the output register; a stalled
// result halts emission only.
module bankers_safety_check_top import bsc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bsc_item_if.sink     i_item,
    bsc_result_if.source o_result,
    bsc_cfg_if.sink      i_cfg
);

    t_dp_cmd    cmd;
    t_dp_status st;

    bsc_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .o_result (o_result),
        .i_cfg    (i_cfg),
        .i_cmd    (cmd),
        .o_st     (st)
    );

    bsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (st),
        .o_cmd   (cmd)
    );

endmodule

// ===== hw/rtl/bsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bsc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/bsc_datapath.sv =====
// Tables, work counts, grant test, safe sequence and output register.
module bsc_datapath import bsc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bsc_item_if.sink      i_item,
    bsc_result_if.source  o_result,
    bsc_cfg_if.sink       i_cfg,
    input  t_dp_cmd       i_cmd,
    output t_dp_status    o_st
);

    logic [NUM_BITS-1:0]   r_cfg_np, r_cfg_nr;
    logic [NUM_BITS-1:0]   r_np, r_nr;
    logic [NUM_BITS-1:0]   start_np, start_nr;
    logic [COUNT_BITS-1:0] r_avail [MAX_RES];
    logic [WORK_BITS-1:0]  r_work  [MAX_RES];
    logic [MAX_PROCS-1:0]  r_finished;
    logic [PROC_BITS-1:0]  r_seq   [MAX_PROCS];
    logic [PROC_BITS-1:0]  r_proc, n_proc;
    logic [PROC_BITS-1:0]  r_pass;
    logic [PROC_BITS-1:0]  r_emit_idx;
    logic [NUM_BITS-1:0]   r_count;
    logic                  r_granted;

    logic                  r_out_valid;
    logic                  r_out_safe;
    logic                  r_out_last;
    logic [PROC_BITS-1:0]  r_out_pid;

    logic [COUNT_BITS-1:0] alloc_rd [MAX_RES];
    logic [COUNT_BITS-1:0] claim_rd [MAX_RES];
    logic [MAX_RES-1:0]    fits;
    logic                  grant_now;
    logic                  in_accept;
    logic                  write_load;
    logic                  is_safe;
    logic                  emit_last;
    t_opcode               in_op;

    assign in_op       = t_opcode'(i_item.opcode);
    assign i_item.ready = i_cmd.in_ready;
    assign in_accept   = i_item.valid && i_cmd.in_ready;
    assign write_load  = in_accept && (in_op != OP_CHECK);

    assign start_np = clamp_count(r_cfg_np, NUM_BITS'(MAX_PROCS));
    assign start_nr = clamp_count(r_cfg_nr, NUM_BITS'(MAX_RES));

    // register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_np <= NUM_BITS'(1);
            r_cfg_nr <= NUM_BITS'(1);
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_NUM_PROCESSES: r_cfg_np <= i_cfg.data;
                CFG_NUM_RESOURCES: r_cfg_nr <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // read address takes the next process index so registered row data lines up with r_proc
    always_comb begin
        if (i_cmd.start || i_cmd.wrap) begin
            n_proc = '0;
        end else if (i_cmd.advance) begin
            n_proc = r_proc + PROC_BITS'(1);
        end else begin
            n_proc = r_proc;
        end
    end

    for (genvar r = 0; r < MAX_RES; r++) begin : g_col
        logic signed [NEED_BITS-1:0] need;
        logic                        in_use;

        bsc_ram #(
            .WIDTH (COUNT_BITS),
            .DEPTH (MAX_PROCS)
        ) u_alloc (
            .i_clk   (i_clk),
            .i_we    (write_load && (in_op == OP_WRITE_ALLOC)
                      && (i_item.resource_index == RES_BITS'(r))),
            .i_waddr (i_item.process_index),
            .i_wdata (i_item.value[COUNT_BITS-1:0]),
            .i_raddr (n_proc),
            .o_rdata (alloc_rd[r])
        );

        bsc_ram #(
            .WIDTH (COUNT_BITS),
            .DEPTH (MAX_PROCS)
        ) u_claim (
            .i_clk   (i_clk),
            .i_we    (write_load && (in_op == OP_WRITE_CLAIM)
                      && (i_item.resource_index == RES_BITS'(r))),
            .i_waddr (i_item.process_index),
            .i_wdata (i_item.value[COUNT_BITS-1:0]),
            .i_raddr (n_proc),
            .o_rdata (claim_rd[r])
        );

        assign in_use = NUM_BITS'(r) < r_nr;
        assign need   = signed'(NEED_BITS'(claim_rd[r])) - signed'(NEED_BITS'(alloc_rd[r]));
        assign fits[r] = !in_use || (need <= signed'(NEED_BITS'(r_work[r])));

        always_ff @(posedge i_clk) begin
            if (write_load && (in_op == OP_WRITE_AVAIL)
                    && (i_item.resource_index == RES_BITS'(r))) begin
                r_avail[r] <= i_item.value[COUNT_BITS-1:0];
            end
            if (i_cmd.start) begin
                r_work[r] <= (NUM_BITS'(r) < start_nr) ? WORK_BITS'(r_avail[r]) : '0;
            end else if (i_cmd.scan && grant_now && in_use) begin
                r_work[r] <= r_work[r] + WORK_BITS'(alloc_rd[r]);
            end
        end
    end

    assign grant_now = !r_finished[r_proc] && (&fits);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_np       <= NUM_BITS'(1);
            r_nr       <= NUM_BITS'(1);
            r_finished <= '0;
            r_count    <= '0;
            r_proc     <= '0;
            r_pass     <= '0;
            r_granted  <= 1'b0;
            r_emit_idx <= '0;
        end else begin
            r_proc <= n_proc;
            if (i_cmd.start) begin
                r_np       <= start_np;
                r_nr       <= start_nr;
                r_finished <= '0;
                r_count    <= '0;
                r_pass     <= '0;
                r_granted  <= 1'b0;
                r_emit_idx <= '0;
            end else begin
                if (i_cmd.scan && grant_now) begin
                    r_finished[r_proc] <= 1'b1;
                    r_count            <= r_count + NUM_BITS'(1);
                end
                if (i_cmd.wrap) begin
                    r_pass    <= r_pass + PROC_BITS'(1);
                    r_granted <= 1'b0;
                end else if (i_cmd.scan) begin
                    r_granted <= r_granted || grant_now;
                end
                if (i_cmd.emit) begin
                    r_emit_idx <= r_emit_idx + PROC_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && grant_now) begin
            r_seq[r_count[PROC_BITS-1:0]] <= r_proc;
        end
    end

    assign is_safe   = (r_count == r_np);
    assign emit_last = !is_safe || (NUM_BITS'(r_emit_idx) == (r_count - NUM_BITS'(1)));

    // output register: hold until transfer, reload on emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_safe <= is_safe;
            r_out_pid  <= is_safe ? r_seq[r_emit_idx] : '0;
            r_out_last <= emit_last;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.safe       = r_out_safe;
    assign o_result.process_id = r_out_pid;
    assign o_result.last       = r_out_last;

    assign o_st.in_valid     = i_item.valid;
    assign o_st.in_is_check  = (in_op == OP_CHECK);
    assign o_st.grant_now    = grant_now;
    assign o_st.pass_granted = r_granted;
    assign o_st.last_proc    = (NUM_BITS'(r_proc) == (r_np - NUM_BITS'(1)));
    assign o_st.last_pass    = (NUM_BITS'(r_pass) == (r_np - NUM_BITS'(1)));
    assign o_st.all_now      = ((r_count + NUM_BITS'(grant_now)) == r_np);
    assign o_st.out_free     = !r_out_valid || o_result.ready;
    assign o_st.emit_last    = emit_last;

`ifndef ASSERT_OFF
    a_finished_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_finished) == int'(r_count))
        else $error("finished flags disagree with safe sequence length");

    a_count_within_procs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_np)
        else $error("more grants than processes in use");

    a_grant_bumps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan && grant_now) |=> (r_count == $past(r_count) + NUM_BITS'(1)))
        else $error("grant did not extend the safe sequence by one");
`endif

endmodule

// ===== hw/rtl/bsc_ctrl.sv =====
// Controller state machine: accept, scan passes, emit results.
module bsc_ctrl import bsc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_status i_st,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_st.in_valid && i_st.in_is_check) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                // stop once everyone is granted, or a pass ends empty or was the last
                if (i_st.all_now || (i_st.last_proc
                        && (!(i_st.pass_granted || i_st.grant_now) || i_st.last_pass))) begin
                    n_state = S_EMIT;
                end else if (i_st.last_proc) begin
                    o_cmd.wrap = 1'b1;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_st.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sim/bankers_safety_check_top_test.sv =====
// Self-checking testbench for the safety checker: table loads, checks and result ordering.
module bankers_safety_check_top_test import bsc_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                 safe;
        logic [PROC_BITS-1:0] pid;
        logic                 last;
    } grant_t;

    // count register as the block applies it when a check starts
    function automatic int clip_count(input logic [NUM_BITS-1:0] v, input int hi);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > hi) begin
            return hi;
        end
        return int'(v);
    endfunction

    class safe_sequence_board;
        logic [VALUE_BITS-1:0] alloc_tbl [MAX_PROCS][MAX_RES];
        logic [VALUE_BITS-1:0] claim_tbl [MAX_PROCS][MAX_RES];
        logic [VALUE_BITS-1:0] avail_cnt [MAX_RES];
        logic [NUM_BITS-1:0]   procs_reg;
        logic [NUM_BITS-1:0]   res_reg;
        grant_t                expected_grants [$];
        int                    errors;

        function new();
            procs_reg = NUM_BITS'(1);
            res_reg   = NUM_BITS'(1);
            errors    = 0;
        endfunction

        function void set_reg(input t_cfg_idx idx, input logic [NUM_BITS-1:0] d);
            if (idx == CFG_NUM_PROCESSES) begin
                procs_reg = d;
            end else begin
                res_reg = d;
            end
        endfunction

        function int pending();
            return expected_grants.size();
        endfunction

        function void predict_safety();
            int                   np, nr;
            logic [WORK_BITS-1:0] work [MAX_RES];
            bit                   done [MAX_PROCS];
            int                   order [$];
            bit                   granted, fits;
            longint               need;
            grant_t               g;
            np = clip_count(procs_reg, MAX_PROCS);
            nr = clip_count(res_reg, MAX_RES);
            for (int r = 0; r < nr; r++) begin
                work[r] = WORK_BITS'(avail_cnt[r]);
            end
            for (int p = 0; p < MAX_PROCS; p++) begin
                done[p] = 1'b0;
            end
            for (int pass = 0; pass < np; pass++) begin
                granted = 1'b0;
                for (int p = 0; p < np; p++) begin
                    if (!done[p]) begin
                        fits = 1'b1;
                        for (int r = 0; r < nr; r++) begin
                            need = longint'(claim_tbl[p][r]) - longint'(alloc_tbl[p][r]);
                            if (need > longint'(work[r])) begin
                                fits = 1'b0;
                            end
                        end
                        if (fits) begin
                            // later rows of this pass see the released units
                            for (int r = 0; r < nr; r++) begin
                                work[r] = work[r] + WORK_BITS'(alloc_tbl[p][r]);
                            end
                            done[p] = 1'b1;
                            order.push_back(p);
                            granted = 1'b1;
                        end
                    end
                end
                if (!granted) begin
                    break;
                end
            end
            if (order.size() != np) begin
                g.safe = 1'b0;
                g.pid  = '0;
                g.last = 1'b1;
                expected_grants.push_back(g);
            end else begin
                foreach (order[k]) begin
                    g.safe = 1'b1;
                    g.pid  = PROC_BITS'(order[k]);
                    g.last = (k == order.size() - 1);
                    expected_grants.push_back(g);
                end
            end
        endfunction

        function void apply_item(input t_opcode op, input logic [PROC_BITS-1:0] pi,
                                 input logic [RES_BITS-1:0] ri,
                                 input logic [VALUE_BITS-1:0] v);
            case (op)
                OP_WRITE_ALLOC: alloc_tbl[pi][ri] = v;
                OP_WRITE_CLAIM: claim_tbl[pi][ri] = v;
                OP_WRITE_AVAIL: avail_cnt[ri] = v;
                default:        predict_safety();
            endcase
        endfunction

        function void match_result(input logic safe, input logic [PROC_BITS-1:0] pid,
                                   input logic last);
            grant_t g;
            if (expected_grants.size() == 0) begin
                $display("%0t: unexpected result safe %0d id %0d last %0d",
                         $time, safe, pid, last);
                errors++;
                return;
            end
            g = expected_grants.pop_front();
            if (safe !== g.safe) begin
                $display("%0t: safe expected %0d got %0d", $time, g.safe, safe);
                errors++;
            end
            if (pid !== g.pid) begin
                $display("%0t: process_id expected %0d got %0d", $time, g.pid, pid);
                errors++;
            end
            if (last !== g.last) begin
                $display("%0t: last expected %0d got %0d", $time, g.last, last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bsc_item_if   item_if ();
    bsc_result_if result_if ();
    bsc_cfg_if    cfg_if ();

    bankers_safety_check_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .i_cfg    (cfg_if)
    );

    safe_sequence_board board = new();

    bit alloc_seen [MAX_PROCS][MAX_RES];
    bit claim_seen [MAX_PROCS][MAX_RES];
    bit avail_seen [MAX_RES];
    int cur_np = 1;
    int cur_nr = 1;
    int items_sent = 0;
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("[bankers_safety_check_top] ERROR");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        result_if.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                result_if.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                result_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready) begin
            board.match_result(result_if.safe, result_if.process_id, result_if.last);
        end
    end

    task automatic send_item(input t_opcode op, input logic [PROC_BITS-1:0] pi,
                             input logic [RES_BITS-1:0] ri, input logic [VALUE_BITS-1:0] v);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        item_if.valid          <= 1'b1;
        item_if.opcode         <= op;
        item_if.process_index  <= pi;
        item_if.resource_index <= ri;
        item_if.value          <= v;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        board.apply_item(op, pi, ri, v);
        items_sent++;
        case (op)
            OP_WRITE_ALLOC: alloc_seen[pi][ri] = 1'b1;
            OP_WRITE_CLAIM: claim_seen[pi][ri] = 1'b1;
            OP_WRITE_AVAIL: avail_seen[ri] = 1'b1;
            default: ;
        endcase
    endtask

    // drop valid and hold until the last result is out, plus a short settle
    task automatic wait_drained();
        item_if.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [NUM_BITS-1:0] d);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= d;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        board.set_reg(idx, d);
    endtask

    task automatic set_config(input logic [NUM_BITS-1:0] np, input logic [NUM_BITS-1:0] nr);
        wait_drained();
        write_reg(CFG_NUM_PROCESSES, np);
        write_reg(CFG_NUM_RESOURCES, nr);
        cfg_if.valid <= 1'b0;
        cur_np = clip_count(np, MAX_PROCS);
        cur_nr = clip_count(nr, MAX_RES);
    endtask

    function automatic logic [VALUE_BITS-1:0] pick_count(input int mode);
        case (mode)
            0:       return VALUE_BITS'($urandom_range(0, 7));
            1:       return VALUE_BITS'($urandom);
            2:       return ($urandom_range(0, 1) == 1) ? '1 : '0;
            default: return VALUE_BITS'($urandom_range(0, 2));
        endcase
    endfunction

    // load any entry of the active region that was never written
    task automatic cover_region();
        for (int p = 0; p < cur_np; p++) begin
            for (int r = 0; r < cur_nr; r++) begin
                if (!alloc_seen[p][r]) begin
                    send_item(OP_WRITE_ALLOC, PROC_BITS'(p), RES_BITS'(r), pick_count(0));
                end
                if (!claim_seen[p][r]) begin
                    send_item(OP_WRITE_CLAIM, PROC_BITS'(p), RES_BITS'(r), pick_count(0));
                end
            end
        end
        for (int r = 0; r < cur_nr; r++) begin
            if (!avail_seen[r]) begin
                send_item(OP_WRITE_AVAIL, PROC_BITS'($urandom), RES_BITS'(r),
                          VALUE_BITS'($urandom_range(0, 15)));
            end
        end
    endtask

    task automatic run_check();
        cover_region();
        send_item(OP_CHECK, PROC_BITS'($urandom), RES_BITS'($urandom),
                  VALUE_BITS'($urandom));
    endtask

    task automatic write_region(input int mode);
        int                    p, r, picks;
        bit                    whole;
        logic [VALUE_BITS-1:0] a, c;
        logic [VALUE_BITS:0]   sum;
        whole = (cur_np * cur_nr <= 8);
        picks = whole ? cur_np * cur_nr : 6;
        for (int k = 0; k < picks; k++) begin
            if (whole) begin
                p = k / cur_nr;
                r = k % cur_nr;
            end else begin
                p = $urandom_range(0, cur_np - 1);
                r = $urandom_range(0, cur_nr - 1);
            end
            a   = pick_count(mode);
            sum = {1'b0, a} + (VALUE_BITS+1)'($urandom_range(0, 4));
            // mostly claims at or just above the allocation, now and then an arbitrary one
            if ($urandom_range(0, 9) == 0) begin
                c = pick_count(mode);
            end else begin
                c = sum[VALUE_BITS] ? '1 : sum[VALUE_BITS-1:0];
            end
            send_item(OP_WRITE_ALLOC, PROC_BITS'(p), RES_BITS'(r), a);
            send_item(OP_WRITE_CLAIM, PROC_BITS'(p), RES_BITS'(r), c);
        end
        for (int k = 0; k < cur_nr; k++) begin
            send_item(OP_WRITE_AVAIL, PROC_BITS'($urandom), RES_BITS'(k),
                      (mode == 0) ? VALUE_BITS'($urandom_range(0, 15)) : pick_count(mode));
        end
    endtask

    task automatic run_scenario();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
            write_region($urandom_range(0, 3));
        end else if (kind <= 8) begin
            // random checks among these must only see written entries
            cover_region();
            repeat ($urandom_range(1, 4)) begin
                send_item(t_opcode'($urandom_range(0, 3)), PROC_BITS'($urandom),
                          RES_BITS'($urandom), VALUE_BITS'($urandom));
            end
        end else begin
            wait_drained();
        end
        run_check();
    endtask

    logic [NUM_BITS-1:0] procs_plan [10] = '{5'd2, 5'd4, 5'd16, 5'd0, 5'd1,
                                             5'd31, 5'd6, 5'd3, 5'd16, 5'd5};
    logic [NUM_BITS-1:0] res_plan   [10] = '{5'd2, 5'd1, 5'd1, 5'd31, 5'd16,
                                             5'd0, 5'd3, 5'd4, 5'd2, 5'd2};

    initial begin
        int start;
        i_rst_n                <= 1'b0;
        item_if.valid          <= 1'b0;
        item_if.opcode         <= OP_WRITE_ALLOC;
        item_if.process_index  <= '0;
        item_if.resource_index <= '0;
        item_if.value          <= '0;
        cfg_if.valid           <= 1'b0;
        cfg_if.index           <= CFG_NUM_PROCESSES;
        cfg_if.data            <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_config(procs_plan[0], res_plan[0]);
        // process 1 fits at once; process 0 only after 1 releases its units
        send_item(OP_WRITE_AVAIL, 4'd0, 4'd0, 16'd3);
        send_item(OP_WRITE_AVAIL, 4'd15, 4'd1, 16'd2);
        send_item(OP_WRITE_AVAIL, 4'd15, 4'd15, 16'hFFFF);
        send_item(OP_WRITE_ALLOC, 4'd0, 4'd0, 16'd1);
        send_item(OP_WRITE_ALLOC, 4'd0, 4'd1, 16'd0);
        send_item(OP_WRITE_ALLOC, 4'd1, 4'd0, 16'd2);
        send_item(OP_WRITE_ALLOC, 4'd1, 4'd1, 16'd1);
        send_item(OP_WRITE_CLAIM, 4'd0, 4'd0, 16'd5);
        send_item(OP_WRITE_CLAIM, 4'd0, 4'd1, 16'd1);
        send_item(OP_WRITE_CLAIM, 4'd1, 4'd0, 16'd3);
        // claim below allocation: negative need
        send_item(OP_WRITE_CLAIM, 4'd1, 4'd1, 16'd0);
        send_item(OP_CHECK, 4'd0, 4'd0, 16'd0);
        // process 0 can never be served
        send_item(OP_WRITE_CLAIM, 4'd0, 4'd0, 16'hFFFF);
        send_item(OP_CHECK, 4'd15, 4'd15, 16'hFFFF);
        send_item(OP_WRITE_ALLOC, 4'd15, 4'd15, 16'hFFFF);
        send_item(OP_WRITE_CLAIM, 4'd15, 4'd15, 16'd0);
        send_item(OP_WRITE_AVAIL, 4'd0, 4'd15, 16'd0);
        send_item(OP_WRITE_CLAIM, 4'd0, 4'd0, 16'd4);
        send_item(OP_CHECK, 4'd7, 4'd9, 16'h5A5A);

        for (int ph = 1; ph < 10; ph++) begin
            set_config(procs_plan[ph], res_plan[ph]);
            if (ph == 1) begin
                hold_req = 1'b1;
            end
            if (ph >= 8) begin
                idle_on = 1'b0;
            end
            start = items_sent;
            // keep offering items through the long hold-off so the input stalls
            while (items_sent - start < ((ph == 1) ? 24 : 4)) begin
                run_scenario();
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("[bankers_safety_check_top] OK");
        end else begin
            $display("[bankers_safety_check_top] ERROR");
        end
        $finish;
    end

endmodule
